### rtl/assert_macros.svh
// Assertion macros for the allocator RTL.
// Depends on signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BFHA_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define BFHA_ASSERT(lbl, prop, msg)
`define BFHA_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/bfha_pkg.sv
// Package of the best-fit heap allocator: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package bfha_pkg;
   localparam int HeapBytes = 4096;
   localparam int Units     = HeapBytes / 8;
   localparam int UW        = $clog2(Units);

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_ARG = 2'd1;
   localparam logic [1:0] ST_NO_MEM  = 2'd3;

   typedef struct packed {
      logic          used;
      logic [UW-1:0] next;
   } hdr_entry_type;

   typedef struct packed {
      logic          rd_en;
      logic [UW-1:0] rd_addr;
      logic          wr_en;
      logic [UW-1:0] wr_addr;
      hdr_entry_type wr_data;
      logic          clear;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE, S_WRD, S_WEV, S_NRD, S_NEV, S_WR1, S_WR2, S_FIN
   } state_type;
endpackage

### rtl/bfha_req_if.sv
// Request channel interface of the allocator.
// Depends on nothing.
`timescale 1ns / 1ps
interface bfha_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] request_size;
   logic [11:0] free_offset;
   modport source (output valid, command, request_size, free_offset, input ready);
   modport sink   (input valid, command, request_size, free_offset, output ready);
endinterface

### rtl/bfha_rsp_if.sv
// Response channel interface of the allocator.
// Depends on nothing.
`timescale 1ns / 1ps
interface bfha_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [12:0] data_offset;
   logic [12:0] used_bytes;
   logic [12:0] fragmented_bytes;
   logic [12:0] largest_used_block;
   modport source (output valid, status, data_offset, used_bytes, fragmented_bytes,
                   largest_used_block, input ready);
   modport sink   (input valid, status, data_offset, used_bytes, fragmented_bytes,
                   largest_used_block, output ready);
endinterface

### rtl/bfha_hdr_mem.sv
// Header table memory, one read and one write port, registered read.
// Depends on bfha_pkg; unit 0 reads as free and last until written.
`timescale 1ns / 1ps
module bfha_hdr_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  bfha_pkg::mem_req_type mem_req,
   output bfha_pkg::hdr_entry_type rd_data
);
   bfha_pkg::hdr_entry_type mem [bfha_pkg::Units];
   bfha_pkg::hdr_entry_type rd_data_ff;
   logic fresh_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // track unit 0 as empty after reset or clear
   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         fresh_ff <= 1'b1;
      end else if (mem_req.wr_en && mem_req.wr_addr == '0) begin
         fresh_ff <= 1'b0;
      end
   end

   // read port, overlay unit 0 while fresh
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         if (fresh_ff && mem_req.rd_addr == '0) begin
            rd_data_ff <= '0;
         end else begin
            rd_data_ff <= mem[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator: header chain in one synchronous memory.
// Alloc, free and report walk the chain block by block (read, evaluate); free then may read
// the block after its target, and alloc and free end with a header write-back.
// One transaction is worked at a time; the next request is taken once the
// result sits in the output register. Reset is synchronous: the arena holds one
// free block and the threshold returns to 256. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module best_fit_heap_allocator (
   input  logic           clock,
   input  logic           reset,
   bfha_req_if.sink       req_chan,
   bfha_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic [12:0]    csr_wr_data
);
   localparam int UW = bfha_pkg::UW;

   bfha_pkg::state_type     state_ff, state_in;
   bfha_pkg::mem_req_type   mem_req;
   bfha_pkg::hdr_entry_type rd;

   logic [12:0]   thr_ff;
   logic [1:0]    cmd_ff, cmd_in;
   logic [13:0]   tu_ff, tu_in;
   logic          big_ff, big_in;
   logic [11:0]   off_ff, off_in;
   logic [UW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic          has_prev_ff, has_prev_in, prev_used_ff, prev_used_in;
   logic [UW-1:0] best_ff, best_in, best_next_ff, best_next_in;
   logic [UW:0]   best_sz_ff, best_sz_in;
   logic          found_ff, found_in;
   logic [UW-1:0] n_ff, n_in, nn_ff, nn_in, mnext_ff, mnext_in;
   logic          n_used_ff, n_used_in;
   logic [12:0]   used_ff, used_in, frag_ff, frag_in, big_blk_ff, big_blk_in;
   logic          pend_ff, pend_in;
   logic [12:0]   pend_sz_ff, pend_sz_in;
   logic [1:0]    status_ff, status_in;
   logic [12:0]   dofs_ff, dofs_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [12:0]   rsp_dofs_ff, rsp_used_ff, rsp_frag_ff, rsp_big_ff;
   logic          load_rsp;

   logic          req_fire;
   logic [16:0]   rounded;
   logic [UW-1:0] n_c, nh_c, nb_c, merged_c;
   logic [UW:0]   sz_c;
   logic [UW-1:0] dunits_c;
   logic [12:0]   szb_c;
   logic          split_c;

   bfha_hdr_mem u_mem (.clock(clock), .reset(reset), .mem_req(mem_req), .rd_data(rd));

   assign req_chan.ready = (state_ff == bfha_pkg::S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rounded        = {1'b0, req_chan.request_size} + 17'd7;

   // decode the block just read
   assign n_c      = (rd.next > cur_ff) ? rd.next : '0;
   assign sz_c     = (n_c != '0) ? ({1'b0, n_c} - {1'b0, cur_ff})
                                 : ((UW+1)'(bfha_pkg::Units) - {1'b0, cur_ff});
   assign dunits_c = UW'(sz_c - (UW+1)'(1));
   assign szb_c    = {sz_c, 3'b000};
   assign split_c  = ({4'b0, best_sz_ff} - 14'd1) > tu_ff;
   assign nh_c     = best_ff + UW'(1) + tu_ff[UW-1:0];
   assign nb_c     = UW'({1'b0, best_ff} + best_sz_ff - {1'b0, tu_ff[UW-1:0]}
                         - (UW+1)'(1));
   assign merged_c = (n_ff != '0 && !n_used_ff) ? nn_ff : n_ff;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 13'd256;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfha_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tu_ff        <= tu_in;
      big_ff       <= big_in;
      off_ff       <= off_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      has_prev_ff  <= has_prev_in;
      prev_used_ff <= prev_used_in;
      best_ff      <= best_in;
      best_next_ff <= best_next_in;
      best_sz_ff   <= best_sz_in;
      found_ff     <= found_in;
      n_ff         <= n_in;
      nn_ff        <= nn_in;
      n_used_ff    <= n_used_in;
      mnext_ff     <= mnext_in;
      used_ff      <= used_in;
      frag_ff      <= frag_in;
      big_blk_ff   <= big_blk_in;
      pend_ff      <= pend_in;
      pend_sz_ff   <= pend_sz_in;
      status_ff    <= status_in;
      dofs_ff      <= dofs_in;
   end

   // next state, memory requests, datapath
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tu_in        = tu_ff;
      big_in       = big_ff;
      off_in       = off_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      has_prev_in  = has_prev_ff;
      prev_used_in = prev_used_ff;
      best_in      = best_ff;
      best_next_in = best_next_ff;
      best_sz_in   = best_sz_ff;
      found_in     = found_ff;
      n_in         = n_ff;
      nn_in        = nn_ff;
      n_used_in    = n_used_ff;
      mnext_in     = mnext_ff;
      used_in      = used_ff;
      frag_in      = frag_ff;
      big_blk_in   = big_blk_ff;
      pend_in      = pend_ff;
      pend_sz_in   = pend_sz_ff;
      status_in    = status_ff;
      dofs_in      = dofs_ff;
      mem_req      = '0;
      load_rsp     = 1'b0;
      case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_chan.command;
               tu_in       = rounded[16:3];
               big_in      = {rounded[16:3], 3'b000} >= {4'b0, thr_ff};
               off_in      = req_chan.free_offset;
               cur_in      = '0;
               has_prev_in = 1'b0;
               found_in    = 1'b0;
               used_in     = '0;
               frag_in     = '0;
               big_blk_in  = '0;
               pend_in     = 1'b0;
               status_in   = bfha_pkg::ST_OK;
               dofs_in     = '0;
               state_in    = bfha_pkg::S_WRD;
               if (req_chan.command == bfha_pkg::CMD_CLEAR) begin
                  mem_req.clear = 1'b1;
                  state_in      = bfha_pkg::S_FIN;
               end else if (req_chan.command == bfha_pkg::CMD_ALLOC
                            && req_chan.request_size == '0) begin
                  status_in = bfha_pkg::ST_BAD_ARG;
                  state_in  = bfha_pkg::S_FIN;
               end else if (req_chan.command == bfha_pkg::CMD_FREE
                            && req_chan.free_offset < 12'd8) begin
                  status_in = bfha_pkg::ST_BAD_ARG;
                  state_in  = bfha_pkg::S_FIN;
               end
            end
         end
         bfha_pkg::S_WRD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_ff;
            state_in        = bfha_pkg::S_WEV;
         end
         bfha_pkg::S_WEV: begin
            state_in = bfha_pkg::S_WRD;
            cur_in   = n_c;
            case (cmd_ff)
               bfha_pkg::CMD_ALLOC: begin
                  // keep the smallest fitting free block, first on ties
                  if (!rd.used && (!found_ff || dunits_c < best_sz_ff[UW-1:0] - UW'(1))
                      && {5'b0, dunits_c} >= tu_ff) begin
                     found_in     = 1'b1;
                     best_in      = cur_ff;
                     best_next_in = n_c;
                     best_sz_in   = sz_c;
                  end
                  if (n_c == '0) begin
                     if (found_ff || found_in) begin
                        state_in = bfha_pkg::S_WR1;
                     end else begin
                        status_in = bfha_pkg::ST_NO_MEM;
                        state_in  = bfha_pkg::S_FIN;
                     end
                  end
               end
               bfha_pkg::CMD_FREE: begin
                  if ({cur_ff, 3'b000} <= off_ff
                      && (n_c == '0 || off_ff <= {n_c, 3'b000})) begin
                     cur_in    = cur_ff;
                     n_in      = n_c;
                     n_used_in = 1'b1;
                     state_in  = (n_c != '0) ? bfha_pkg::S_NRD : bfha_pkg::S_WR1;
                  end else begin
                     prev_in      = cur_ff;
                     prev_used_in = rd.used;
                     has_prev_in  = 1'b1;
                  end
               end
               default: begin
                  // report: settle the pending free block once its right side is known
                  if (pend_ff && rd.used) begin
                     frag_in = frag_ff + pend_sz_ff;
                  end
                  if (rd.used) begin
                     used_in = used_ff + szb_c;
                     if (szb_c > big_blk_ff) begin
                        big_blk_in = szb_c;
                     end
                  end
                  pend_in      = !rd.used && has_prev_ff && prev_used_ff;
                  pend_sz_in   = szb_c;
                  prev_used_in = rd.used;
                  has_prev_in  = 1'b1;
                  if (n_c == '0) begin
                     state_in = bfha_pkg::S_FIN;
                  end
               end
            endcase
         end
         bfha_pkg::S_NRD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = n_ff;
            state_in        = bfha_pkg::S_NEV;
         end
         bfha_pkg::S_NEV: begin
            n_used_in = rd.used;
            nn_in     = (rd.next > n_ff) ? rd.next : '0;
            state_in  = bfha_pkg::S_WR1;
         end
         bfha_pkg::S_WR1: begin
            state_in = bfha_pkg::S_WR2;
            if (cmd_ff == bfha_pkg::CMD_FREE) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cur_ff;
               mem_req.wr_data = '{used: 1'b0, next: merged_c};
               mnext_in        = merged_c;
               if (!(has_prev_ff && !prev_used_ff)) begin
                  state_in = bfha_pkg::S_FIN;
               end
            end else if (!big_ff) begin
               mem_req.wr_en   = split_c;
               mem_req.wr_addr = nh_c;
               mem_req.wr_data = '{used: 1'b0, next: best_next_ff};
            end else begin
               mem_req.wr_en   = (nb_c != best_ff);
               mem_req.wr_addr = best_ff;
               mem_req.wr_data = '{used: 1'b0, next: nb_c};
            end
         end
         bfha_pkg::S_WR2: begin
            state_in      = bfha_pkg::S_FIN;
            mem_req.wr_en = 1'b1;
            if (cmd_ff == bfha_pkg::CMD_FREE) begin
               mem_req.wr_addr = prev_ff;
               mem_req.wr_data = '{used: 1'b0, next: mnext_ff};
            end else if (!big_ff) begin
               mem_req.wr_addr = best_ff;
               mem_req.wr_data = '{used: 1'b1, next: split_c ? nh_c : best_next_ff};
               dofs_in         = {1'b0, best_ff + UW'(1), 3'b000};
               if (best_ff == UW'(bfha_pkg::Units - 1)) begin
                  dofs_in = 13'(bfha_pkg::HeapBytes);
               end
            end else begin
               mem_req.wr_addr = nb_c;
               mem_req.wr_data = '{used: 1'b1, next: best_next_ff};
               dofs_in         = {1'b0, nb_c, 3'b000} + 13'd8;
            end
         end
         bfha_pkg::S_FIN: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = bfha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfha_pkg::S_IDLE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_dofs_ff   <= dofs_ff;
         rsp_used_ff   <= used_ff;
         rsp_frag_ff   <= frag_ff;
         rsp_big_ff    <= big_blk_ff;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.data_offset        = rsp_dofs_ff;
   assign rsp_chan.used_bytes         = rsp_used_ff;
   assign rsp_chan.fragmented_bytes   = rsp_frag_ff;
   assign rsp_chan.largest_used_block = rsp_big_ff;

   `BFHA_ASSERT(a_busy_after_accept, req_fire |=> state_ff != bfha_pkg::S_IDLE, "accept left idle")
   `BFHA_ASSERT(a_write_state, mem_req.wr_en |-> (state_ff == bfha_pkg::S_WR1 || state_ff == bfha_pkg::S_WR2), "write outside write-back")
   `BFHA_NEVER(a_fail_offset, rsp_valid_ff && rsp_status_ff != bfha_pkg::ST_OK && rsp_dofs_ff != '0, "offset on failure")
endmodule
